>>> design/urm_pkg.sv
// Shared types and constants for the ultrasonic ranging median block.
// Used by urm_ctrl, urm_datapath and ultrasonic_ranging_median; no dependencies.
package urm_pkg;

   // Fixed field widths.
   localparam int TIMER_BITS = 16;
   localparam int OVF_W      = 8;
   localparam int Q24_W      = 24;
   localparam int TICKS_W    = 24;
   localparam int DIST_W     = 22;
   localparam int SEQ_W      = 3;
   localparam int CMD_W      = 2;

   // Packed channel widths, padded to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   localparam logic [Q24_W-1:0]  CFG_RESET = 24'd287729;
   localparam logic [DIST_W-1:0] DIST_MAX  = 22'h3F_FFFF;

   // Host commands.
   localparam logic [CMD_W-1:0] CMD_FIRE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   // Ranging sequencer state codes as seen on the result channel.
   localparam logic [SEQ_W-1:0] SEQ_WAIT_START      = 3'd0;
   localparam logic [SEQ_W-1:0] SEQ_TRIGGER         = 3'd1;
   localparam logic [SEQ_W-1:0] SEQ_WAIT_ECHO_START = 3'd2;
   localparam logic [SEQ_W-1:0] SEQ_WAIT_ECHO_END   = 3'd3;
   localparam logic [SEQ_W-1:0] SEQ_SET_DISTANCE    = 3'd4;

   // Controller states, one-hot.
   typedef enum logic [5:0] {
      CTL_IDLE   = 6'b000001,
      CTL_MUL    = 6'b000010,
      CTL_STORE  = 6'b000100,
      CTL_SORT   = 6'b001000,
      CTL_MEDIAN = 6'b010000,
      CTL_EMIT   = 6'b100000
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic store;
      logic sort_step;
      logic median;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rec;        // the item being offered records a sample
      logic last;       // the sample being stored completes a block
      logic sort_done;  // current sort pass is the final one
      logic slot_free;  // the result register can take a new item
   } sts_type;

endpackage

>>> design/urm_ctrl.sv
// Controller state machine for the ultrasonic ranging median block.
// Depends on urm_pkg; drives urm_datapath through cmd_type and reads sts_type.
module urm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  urm_pkg::sts_type sts,
   output urm_pkg::cmd_type cmd
);
   import urm_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          accept;

   assign req_tready = (state_ff == CTL_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               state_in = sts.rec ? CTL_MUL : CTL_EMIT;
            end
         end
         CTL_MUL: begin
            state_in = CTL_STORE;
         end
         CTL_STORE: begin
            state_in = sts.last ? CTL_SORT : CTL_EMIT;
         end
         CTL_SORT: begin
            if (sts.sort_done) begin
               state_in = CTL_MEDIAN;
            end
         end
         CTL_MEDIAN: begin
            state_in = CTL_EMIT;
         end
         CTL_EMIT: begin
            if (sts.slot_free) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.mul       = (state_ff == CTL_MUL);
      cmd.store     = (state_ff == CTL_STORE);
      cmd.sort_step = (state_ff == CTL_SORT);
      cmd.median    = (state_ff == CTL_MEDIAN);
      cmd.emit      = (state_ff == CTL_EMIT) && sts.slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/urm_datapath.sv
// Datapath of the ultrasonic ranging median block: sequencer registers, echo
// width, scaling multiplier, sample store, sort network, median and result register.
// Depends on urm_pkg; commanded by urm_ctrl.
module urm_datapath #(
   parameter int NUM_SAMPLES = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [urm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [urm_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [urm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [urm_pkg::Q24_W-1:0]        csr_wr_data,
   input  urm_pkg::cmd_type                 cmd,
   output urm_pkg::sts_type                 sts
);
   import urm_pkg::*;

   localparam int IDX_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

   // Unpacked request fields.
   logic [CMD_W-1:0]      command;
   logic                  trigger_ok;
   logic                  trigger_end;
   logic [TIMER_BITS-1:0] echo_rise_tick;
   logic [TIMER_BITS-1:0] echo_fall_tick;
   logic [OVF_W-1:0]      echo_wraps;
   logic                  echo_received;

   assign command        = req_tuser;
   assign trigger_ok     = req_tdata[0];
   assign trigger_end    = req_tdata[1];
   assign echo_rise_tick = req_tdata[17:2];
   assign echo_fall_tick = req_tdata[33:18];
   assign echo_wraps     = req_tdata[41:34];
   assign echo_received  = req_tdata[42];

   logic [Q24_W-1:0]   cfg_ff, cfg_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic               enabled_ff, enabled_in;
   logic [DIST_W-1:0]  median_ff, median_in;
   logic               ready_ff, ready_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   pass_ff, pass_in;
   logic [3:0]         pulse_ff, pulse_in;  // start, stop trigger, stop echo, stop sensor
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [2*Q24_W-1:0] prod_ff, prod_in;
   logic [DIST_W-1:0]  store_ff [NUM_SAMPLES];
   logic [DIST_W-1:0]  store_in [NUM_SAMPLES];
   logic [DIST_W-1:0]  sorted_w [NUM_SAMPLES];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               rec_w;
   logic [OVF_W-1:0]   ovf_eff;
   logic [TICKS_W-1:0] cm_raw;
   logic [DIST_W-1:0]  cm_sat;
   logic [DIST_W:0]    mid_sum;
   logic [DIST_W-1:0]  median_w;

   assign rec_w = (command == CMD_FIRE) && (seq_ff == SEQ_WAIT_ECHO_END) && echo_received;

   // A wrapped echo with no overflow counted still spans one wrap.
   assign ovf_eff = ((echo_fall_tick < echo_rise_tick) && (echo_wraps == '0)) ?
                    OVF_W'(1) : echo_wraps;
   assign ticks_in = {ovf_eff, TIMER_BITS'(0)}
                   + {{(TICKS_W-TIMER_BITS){1'b0}}, echo_fall_tick}
                   - {{(TICKS_W-TIMER_BITS){1'b0}}, echo_rise_tick};

   assign prod_in = {{Q24_W{1'b0}}, ticks_ff} * {{Q24_W{1'b0}}, cfg_ff};
   assign cm_raw  = prod_ff[2*Q24_W-1:Q24_W];
   assign cm_sat  = (cm_raw[TICKS_W-1:DIST_W] != '0) ? DIST_MAX : cm_raw[DIST_W-1:0];

   // One odd-even transposition phase over disjoint neighbor pairs.
   always_comb begin
      sorted_w = store_ff;
      for (int j = 0; j < NUM_SAMPLES - 1; j++) begin
         if ((j[0] == pass_ff[0]) && (store_ff[j] > store_ff[j+1])) begin
            sorted_w[j]   = store_ff[j+1];
            sorted_w[j+1] = store_ff[j];
         end
      end
   end

   always_comb begin
      mid_sum = '0;
      if ((NUM_SAMPLES % 2) == 0) begin
         mid_sum  = {1'b0, store_ff[NUM_SAMPLES/2-1]} + {1'b0, store_ff[NUM_SAMPLES/2]};
         median_w = mid_sum[DIST_W:1];
      end else begin
         median_w = store_ff[NUM_SAMPLES/2];
      end
   end

   always_comb begin
      cfg_in     = csr_wr_en ? csr_wr_data : cfg_ff;
      seq_in     = seq_ff;
      enabled_in = enabled_ff;
      median_in  = median_ff;
      ready_in   = ready_ff;
      idx_in     = idx_ff;
      pass_in    = pass_ff;
      pulse_in   = pulse_ff;
      store_in   = store_ff;

      if (cmd.load) begin
         pulse_in = '0;
         case (command)
            CMD_START: begin
               enabled_in = 1'b1;
               idx_in     = '0;
               median_in  = '0;
            end
            CMD_STOP: begin
               enabled_in  = 1'b0;
               pulse_in[3] = 1'b1;
            end
            CMD_READ: begin
               ready_in = 1'b0;
            end
            default: begin
               case (seq_ff)
                  SEQ_TRIGGER: begin
                     if (trigger_end) begin
                        seq_in      = SEQ_WAIT_ECHO_START;
                        pulse_in[1] = 1'b1;
                     end
                  end
                  SEQ_WAIT_ECHO_START: begin
                     if (echo_rise_tick != '0) begin
                        seq_in = SEQ_WAIT_ECHO_END;
                     end
                  end
                  SEQ_WAIT_ECHO_END: begin
                     if (echo_received) begin
                        seq_in      = SEQ_SET_DISTANCE;
                        pulse_in[2] = 1'b1;
                     end
                  end
                  SEQ_SET_DISTANCE: begin
                     if (trigger_ok) begin
                        seq_in      = SEQ_TRIGGER;
                        pulse_in[0] = 1'b1;
                     end else if (!enabled_ff) begin
                        seq_in      = SEQ_WAIT_START;
                        pulse_in[3] = 1'b1;
                     end
                  end
                  default: begin
                     if (enabled_ff && trigger_ok) begin
                        seq_in      = SEQ_TRIGGER;
                        pulse_in[0] = 1'b1;
                     end
                  end
               endcase
            end
         endcase
      end

      if (cmd.store) begin
         store_in[idx_ff] = cm_sat;
         idx_in  = sts.last ? '0 : idx_ff + IDX_W'(1);
         pass_in = '0;
      end

      if (cmd.sort_step) begin
         store_in = sorted_w;
         pass_in  = pass_ff + IDX_W'(1);
      end

      if (cmd.median) begin
         median_in = median_w;
         ready_in  = 1'b1;
      end
   end

   assign sts.rec       = rec_w;
   assign sts.last      = (idx_ff == IDX_W'(NUM_SAMPLES - 1));
   assign sts.sort_done = (pass_ff == IDX_W'(NUM_SAMPLES - 1));
   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, pulse_ff[3], pulse_ff[2], pulse_ff[1], pulse_ff[0],
                         ready_ff, median_ff, seq_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         seq_ff       <= SEQ_WAIT_START;
         enabled_ff   <= 1'b0;
         median_ff    <= '0;
         ready_ff     <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         seq_ff       <= seq_in;
         enabled_ff   <= enabled_in;
         median_ff    <= median_in;
         ready_ff     <= ready_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pulse_ff    <= pulse_in;
      store_ff    <= store_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         ticks_ff <= ticks_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

endmodule

>>> design/ultrasonic_ranging_median.sv
// Top level of the ultrasonic ranging median block.
// Depends on urm_pkg, urm_ctrl and urm_datapath.
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         tvalid/tready          one host command with sensor flags and ticks
//   rsp_*     out        tvalid/tready          sequencer state, median, flag and pulses
//   csr_*     in         write enable only      cm_per_tick_q24 scale factor
//
// An item that records no sample goes from accept to emit; one that records a sample
// also passes multiply and store, and one that completes a block of NUM_SAMPLES also
// runs sort and median: one odd-even transposition pass per cycle over the sample store.
// Reset is synchronous and active high; it restores the sequencer, the flag, the
// median and the scale factor, and the block is ready in the next cycle.
// A new item is accepted while the previous result still waits in the result register;
// its own result waits in the controller until that register is taken.
module ultrasonic_ranging_median #(
   parameter int NUM_SAMPLES = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request item.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // From bit 0: trigger_ok, trigger_end, echo_rise_tick[15:0], echo_fall_tick[15:0],
   // echo_wraps[7:0], echo_received, zero padding.
   input  logic [urm_pkg::REQ_DATA_W-1:0] req_tdata,
   // From bit 0: command[1:0].
   input  logic [urm_pkg::CMD_W-1:0]      req_tuser,
   // Result item.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // From bit 0: fsm_state[2:0], range_cm[21:0], measurement_ready, start_trigger,
   // stop_trigger, stop_echo, stop_sensor, zero padding.
   output logic [urm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Scale factor write.
   input  logic                           csr_wr_en,
   input  logic [urm_pkg::Q24_W-1:0]      csr_wr_data
);
   import urm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller sequences each item: accept, optional multiply and store,
   // optional sort and median, then hand the result to the output register.
   urm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds every architectural register, including the ranging
   // sequencer state, the sample store and the result register.
   urm_datapath #(
      .NUM_SAMPLES (NUM_SAMPLES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   // One item at a time: an accept moves the controller out of idle, so it is not ready right after it.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a previous item was still in progress");

   // At most one datapath command is active in any cycle.
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // A result is only written into a free output register, so none is lost.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result written over one not yet taken");

   // A sort pass is only ever entered from a store that completed a block.
   a_sort_entry: assert property (@(posedge clock) disable iff (reset)
      ($rose(cmd.sort_step)) |-> $past(cmd.store && sts.last))
      else $error("sort started without a completed block");

endmodule
